### design/point_projection_depth_buffer_core_assert.svh
// Assertion helpers for the depth buffer core.
`ifndef POINT_PROJECTION_DEPTH_BUFFER_CORE_ASSERT_SVH
`define POINT_PROJECTION_DEPTH_BUFFER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPDB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppdb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppdb: next-cycle check failed");

`endif

### design/ppdb_pkg.sv
package ppdb_pkg;

    // Width that holds any map dimension
    localparam int DIM_W = 13;

    // Command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_ROT0  = 3'd0;
    localparam logic [2:0] REG_ROT1  = 3'd1;
    localparam logic [2:0] REG_ROT2  = 3'd2;
    localparam logic [2:0] REG_SHXY  = 3'd3;
    localparam logic [2:0] REG_SHZ   = 3'd4;
    localparam logic [2:0] REG_FOCAL = 3'd5;
    localparam logic [2:0] REG_PRINC = 3'd6;

    // Reset values
    localparam logic [53:0] ROT0_RST  = 54'h10_0000_0000_0000;
    localparam logic [53:0] ROT1_RST  = 54'h4_0000_0000;
    localparam logic [53:0] ROT2_RST  = 54'h1_0000;
    localparam logic [63:0] FOCAL_RST = 64'h01F4_0000_01F4_0000;
    localparam logic [63:0] PRINC_RST = 64'h0200_0000_0100_0000;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [9:0]         read_col;
        logic [8:0]         read_row;
    } req_t;

    typedef struct packed {
        logic [31:0] range_value;
        logic [2:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [53:0]        rot_row_first;
        logic [53:0]        rot_row_second;
        logic [53:0]        rot_row_third;
        logic [63:0]        shift_xy;
        logic signed [31:0] shift_z;
        logic [63:0]        focal_xy;
        logic [63:0]        principal_xy;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_BEHIND  = 3'd1,
        ST_OUTSIDE = 3'd2,
        ST_FARTHER = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_DONE    = 3'd5
    } status_e;

    typedef enum logic [1:0] {SRC_ZERO, SRC_RANGE, SRC_MEM} src_e;

    typedef enum logic [1:0] {MOP_CAM, MOP_SQ, MOP_FX, MOP_FY} mop_e;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CAM, S_CAMW, S_CAMF, S_SQ, S_SQW, S_SQRI, S_SQRT,
        S_PX, S_PXI, S_DIVX, S_PY, S_PYI, S_DIVY, S_BND, S_RBND, S_BCHK,
        S_MCMP, S_CLR, S_DONE
    } state_e;

    // Controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       acc_init;
        logic       mul_go;
        mop_e       mul_op;
        logic [1:0] mul_axis;
        logic [1:0] mul_term;
        logic       cam_fin;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       save_qx;
        logic       bnd_pt;
        logic       bnd_rd;
        logic       mem_rd;
        logic       mem_wr;
        logic       sweep_step;
        src_e       src;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic behind;
        logic outside;
        logic hit_valid;
        logic hit_nearer;
        logic sweep_last;
    } dp_stat_t;

endpackage

### design/ppdb_ctrl.sv
module ppdb_ctrl
    import ppdb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_command,
    input  logic       out_free,
    input  dp_stat_t   stat,
    output logic       req_ready,
    output logic       push,
    output status_e    rsp_status,
    output ctrl_cmd_t  cmd
);

    state_e  state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic    is_add_reg, is_add_next;
    status_e res_status_reg, res_status_next;
    src_e    res_src_reg, res_src_next;

    // State and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            is_add_reg     <= 1'b0;
            res_status_reg <= ST_DONE;
            res_src_reg    <= SRC_ZERO;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            is_add_reg     <= is_add_next;
            res_status_reg <= res_status_next;
            res_src_reg    <= res_src_next;
        end
    end

    assign rsp_status = res_status_reg;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        is_add_next     = is_add_reg;
        res_status_next = res_status_reg;
        res_src_next    = res_src_reg;
        cmd             = '0;
        cmd.src         = res_src_reg;
        req_ready       = 1'b0;
        push            = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    cnt_next     = '0;
                    is_add_next  = (req_command == CMD_ADD);
                    unique case (req_command)
                        CMD_ADD:
                        begin
                            cmd.acc_init = 1'b1;
                            state_next   = S_CAM;
                        end
                        CMD_CLEAR: state_next = S_CLR;
                        default:   state_next = S_RBND;
                    endcase
                end
            end
            // nine rotation products, axis in cnt[3:2], term in cnt[1:0]
            S_CAM:
            begin
                cmd.mul_go   = 1'b1;
                cmd.mul_op   = MOP_CAM;
                cmd.mul_axis = cnt_reg[3:2];
                cmd.mul_term = cnt_reg[1:0];
                if (cnt_reg[1:0] == 2'd2)
                begin
                    cnt_next = {cnt_reg[5:4], cnt_reg[3:2] + 2'd1, 2'd0};
                    if (cnt_reg[3:2] == 2'd2)
                        state_next = S_CAMW;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_CAMW: state_next = S_CAMF;
            S_CAMF:
            begin
                cmd.cam_fin = 1'b1;
                cnt_next    = '0;
                state_next  = S_SQ;
            end
            S_SQ:
            begin
                cmd.mul_go   = 1'b1;
                cmd.mul_op   = MOP_SQ;
                cmd.mul_axis = cnt_reg[1:0];
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == 2'd2)
                    state_next = S_SQW;
            end
            S_SQW: state_next = S_SQRI;
            S_SQRI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    if (stat.behind)
                    begin
                        res_status_next = ST_BEHIND;
                        res_src_next    = SRC_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_PX;
                end
            end
            S_PX:
            begin
                cmd.mul_go   = 1'b1;
                cmd.mul_op   = MOP_FX;
                cmd.mul_axis = 2'd0;
                state_next   = S_PXI;
            end
            S_PXI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIVX;
            end
            S_DIVX:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_PY;
            end
            S_PY:
            begin
                cmd.save_qx  = 1'b1;
                cmd.mul_go   = 1'b1;
                cmd.mul_op   = MOP_FY;
                cmd.mul_axis = 2'd1;
                state_next   = S_PYI;
            end
            S_PYI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIVY;
            end
            S_DIVY:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_BND;
            end
            S_BND:
            begin
                cmd.bnd_pt = 1'b1;
                state_next = S_BCHK;
            end
            S_RBND:
            begin
                cmd.bnd_rd = 1'b1;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (stat.outside)
                begin
                    res_status_next = ST_OUTSIDE;
                    res_src_next    = is_add_reg ? SRC_RANGE : SRC_ZERO;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_MCMP;
                end
            end
            // depth test for an add, hit check for a read
            S_MCMP:
            begin
                state_next = S_DONE;
                if (is_add_reg)
                begin
                    res_src_next = SRC_RANGE;
                    if (stat.hit_valid && stat.hit_nearer)
                        res_status_next = ST_FARTHER;
                    else
                    begin
                        cmd.mem_wr      = 1'b1;
                        res_status_next = ST_STORED;
                    end
                end
                else if (stat.hit_valid)
                begin
                    res_status_next = ST_DONE;
                    res_src_next    = SRC_MEM;
                end
                else
                begin
                    res_status_next = ST_EMPTY;
                    res_src_next    = SRC_ZERO;
                end
            end
            S_CLR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    res_status_next = ST_DONE;
                    res_src_next    = SRC_ZERO;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### design/ppdb_dpath.sv
module ppdb_dpath
    import ppdb_pkg::*;
#(
    parameter int MAP_WIDTH  = 1024,
    parameter int MAP_HEIGHT = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  req_t        req,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    output logic [31:0] res_range
);

    localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAP_WIDTH);
    localparam int ROW_W  = $clog2(MAP_HEIGHT);

    typedef struct packed {
        logic        ok;
        logic [25:0] coord;
    } ax_t;

    // Floor of a Q32 accumulator back to Q16.16, saturated
    function automatic logic signed [31:0] sat_cam(input logic signed [53:0] a);
        logic signed [37:0] sh;
        sh = $signed(a[53:16]);
        if (sh > 38'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (sh < -38'sd2147483648)
            return 32'sh8000_0000;
        else
            return $signed(sh[31:0]);
    endfunction

    // Clamp quotient, add principal point, truncate to pixel and range check
    function automatic ax_t proj_axis(input logic [63:0] q, input logic neg,
                                      input logic [31:0] k, input logic [25:0] lim);
        ax_t r;
        logic [40:0] qs;
        logic signed [42:0] u;
        qs = (q > 64'h100_0000_0000) ? 41'h100_0000_0000 : q[40:0];
        if (neg)
            u = $signed({11'b0, k}) - $signed({2'b0, qs});
        else
            u = $signed({2'b0, qs}) + $signed({11'b0, k});
        if (u[42])
        begin
            r.ok    = (u > -43'sd65536);
            r.coord = '0;
        end
        else
        begin
            r.coord = u[41:16];
            r.ok    = (u[41:16] < lim);
        end
        return r;
    endfunction

    req_t               req_q_reg;
    logic signed [53:0] acc_reg [3];
    logic signed [31:0] cam_reg [3];
    logic signed [65:0] prod_reg;
    logic               pv_reg;
    mop_e               pop_reg;
    logic [1:0]         paxis_reg;
    logic [63:0]        sq_acc_reg;
    logic [63:0]        sqr_reg;
    logic [32:0]        srem_reg;
    logic [31:0]        root_reg;
    logic [63:0]        num_reg;
    logic [31:0]        drem_reg;
    logic [63:0]        qx_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               outside_reg;
    logic [32:0]        rd_data_reg;
    logic [ADDR_W-1:0]  sweep_addr_reg;
    logic [32:0]        mem [DEPTH];

    logic [53:0]        rot_row;
    logic [17:0]        rot_ent;
    logic signed [31:0] pt_sel;
    logic signed [31:0] cam_sel;
    logic [31:0]        cam_mag;
    logic signed [32:0] mul_a, mul_b;
    logic [34:0]        s_t, s_trial;
    logic               s_ge;
    logic [32:0]        d_t, d_div;
    logic               d_ge;
    ax_t                ax_x, ax_y;
    logic [25:0]        sel_col, sel_row;
    logic               sel_ok;
    logic [ADDR_W-1:0]  addr_next;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [32:0]        wr_data;

    // Multiplier operand selection
    always_comb
    begin
        case (cmd.mul_axis)
            2'd0:    rot_row = cfg.rot_row_first;
            2'd1:    rot_row = cfg.rot_row_second;
            default: rot_row = cfg.rot_row_third;
        endcase
        case (cmd.mul_term)
            2'd0:
            begin
                rot_ent = rot_row[53:36];
                pt_sel  = req_q_reg.point_x;
            end
            2'd1:
            begin
                rot_ent = rot_row[35:18];
                pt_sel  = req_q_reg.point_y;
            end
            default:
            begin
                rot_ent = rot_row[17:0];
                pt_sel  = req_q_reg.point_z;
            end
        endcase
        case (cmd.mul_axis)
            2'd0:    cam_sel = cam_reg[0];
            2'd1:    cam_sel = cam_reg[1];
            default: cam_sel = cam_reg[2];
        endcase
        cam_mag = cam_sel[31] ? (~cam_sel + 32'd1) : cam_sel;
        case (cmd.mul_op)
            MOP_CAM:
            begin
                mul_a = $signed({{15{rot_ent[17]}}, rot_ent});
                mul_b = $signed({pt_sel[31], pt_sel});
            end
            MOP_SQ:
            begin
                mul_a = $signed({1'b0, cam_mag});
                mul_b = $signed({1'b0, cam_mag});
            end
            MOP_FX:
            begin
                mul_a = $signed({1'b0, cfg.focal_xy[63:32]});
                mul_b = $signed({1'b0, cam_mag});
            end
            default:
            begin
                mul_a = $signed({1'b0, cfg.focal_xy[31:0]});
                mul_b = $signed({1'b0, cam_mag});
            end
        endcase
    end

    // Square root step: two radicand bits per cycle
    assign s_t     = {srem_reg, sqr_reg[63:62]};
    assign s_trial = {1'b0, root_reg, 2'b01};
    assign s_ge    = (s_t >= s_trial);

    // Restoring divide step by camera z
    assign d_t  = {drem_reg, num_reg[63]};
    assign d_div = {2'b0, cam_reg[2][30:0]};
    assign d_ge = (d_t >= d_div);

    // Pixel selection for an add or a read
    always_comb
    begin
        ax_x = proj_axis(qx_reg, cam_reg[0][31], cfg.principal_xy[63:32], 26'(MAP_WIDTH));
        ax_y = proj_axis(num_reg, cam_reg[1][31], cfg.principal_xy[31:0], 26'(MAP_HEIGHT));
        if (cmd.bnd_rd)
        begin
            sel_col = {16'b0, req_q_reg.read_col};
            sel_row = {17'b0, req_q_reg.read_row};
            sel_ok  = ({3'b0, req_q_reg.read_col} < DIM_W'(MAP_WIDTH)) &&
                      ({4'b0, req_q_reg.read_row} < DIM_W'(MAP_HEIGHT));
        end
        else
        begin
            sel_col = ax_x.coord;
            sel_row = ax_y.coord;
            sel_ok  = ax_x.ok && ax_y.ok;
        end
        addr_next = ADDR_W'(sel_row[ROW_W-1:0]) * ADDR_W'(MAP_WIDTH) +
                    ADDR_W'(sel_col[COL_W-1:0]);
    end

    // Arithmetic registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg         <= 1'b0;
            sweep_addr_reg <= '0;
        end
        else
        begin
            pv_reg <= cmd.mul_go;
            if (cmd.sweep_step)
                sweep_addr_reg <= stat.sweep_last ? '0 : sweep_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_q_reg <= req;
        if (cmd.mul_go)
        begin
            prod_reg  <= mul_a * mul_b;
            pop_reg   <= cmd.mul_op;
            paxis_reg <= cmd.mul_axis;
        end
        if (cmd.acc_init)
        begin
            acc_reg[0] <= $signed({{6{cfg.shift_xy[63]}}, cfg.shift_xy[63:32], 16'b0});
            acc_reg[1] <= $signed({{6{cfg.shift_xy[31]}}, cfg.shift_xy[31:0], 16'b0});
            acc_reg[2] <= $signed({{6{cfg.shift_z[31]}}, cfg.shift_z, 16'b0});
            sq_acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            case (pop_reg)
                MOP_CAM: acc_reg[paxis_reg] <= acc_reg[paxis_reg] + prod_reg[53:0];
                MOP_SQ:  sq_acc_reg <= sq_acc_reg + prod_reg[63:0];
                default: ;
            endcase
        end
        if (cmd.cam_fin)
        begin
            cam_reg[0] <= sat_cam(acc_reg[0]);
            cam_reg[1] <= sat_cam(acc_reg[1]);
            cam_reg[2] <= sat_cam(acc_reg[2]);
        end
        if (cmd.sqrt_init)
        begin
            sqr_reg  <= sq_acc_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sqr_reg  <= {sqr_reg[61:0], 2'b00};
            srem_reg <= s_ge ? 33'(s_t - s_trial) : s_t[32:0];
            root_reg <= {root_reg[30:0], s_ge};
        end
        if (cmd.div_init)
        begin
            num_reg  <= prod_reg[63:0];
            drem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg  <= {num_reg[62:0], d_ge};
            drem_reg <= d_ge ? 32'(d_t - d_div) : d_t[31:0];
        end
        if (cmd.save_qx)
            qx_reg <= num_reg;
        if (cmd.bnd_pt || cmd.bnd_rd)
        begin
            addr_reg    <= addr_next;
            outside_reg <= !sel_ok;
        end
    end

    // Range map: one write port, one registered read port
    assign wr_en   = cmd.sweep_step || cmd.mem_wr;
    assign wr_addr = cmd.sweep_step ? sweep_addr_reg : addr_reg;
    assign wr_data = cmd.sweep_step ? 33'b0 : {1'b1, root_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_rd)
            rd_data_reg <= mem[addr_reg];
    end

    // Status and result
    assign stat.behind     = cam_reg[2][31] || (cam_reg[2] == 32'sd0);
    assign stat.outside    = outside_reg;
    assign stat.hit_valid  = rd_data_reg[32];
    assign stat.hit_nearer = (rd_data_reg[31:0] < root_reg);
    assign stat.sweep_last = (sweep_addr_reg == ADDR_W'(DEPTH - 1));

    always_comb
    begin
        case (cmd.src)
            SRC_RANGE: res_range = root_reg;
            SRC_MEM:   res_range = rd_data_reg[31:0];
            default:   res_range = '0;
        endcase
    end

endmodule

### design/point_projection_depth_buffer_core.sv
// Lidar point projection into a nearest-range pixel map.
// Request channel (req_valid/req_ready/req): add a point, read a pixel or
// clear the map. Response channel (rsp_valid/rsp_ready/rsp): exactly one
// response per request, in order, carrying a range and a status code.
// Configuration (cfg_we/cfg_index/cfg_data): single-cycle register writes,
// only while no request is in flight; the user must keep to this, as the
// core does not enforce it. One request at a time. Add: 9 rotation
// products and 3 squares on one shared 33x33 multiplier, 32 square-root
// steps, two 64-step restoring divides, one read and at most one write
// of the map; it ends early when the pixel falls outside the map or the
// point is behind the camera. Read: one read of the map, skipped when the
// pixel is outside the map. Clear: one map entry cleared per cycle. After
// reset the map is swept the same way, with req_ready low; configuration
// writes are taken during the sweep.
// A finished response sits in an output register; the next request is
// taken while it waits. If the receiver stalls with a response still held,
// the core holds its next result until the register frees.
`include "point_projection_depth_buffer_core_assert.svh"

module point_projection_depth_buffer_core
    import ppdb_pkg::*;
#(
    parameter int MAP_WIDTH  = 1024,
    parameter int MAP_HEIGHT = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_t        cfg_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    logic        push;
    logic        out_free;
    status_e     rsp_status;
    ctrl_cmd_t   cmd;
    dp_stat_t    stat;
    logic [31:0] res_range;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_row_first  <= ROT0_RST;
            cfg_reg.rot_row_second <= ROT1_RST;
            cfg_reg.rot_row_third  <= ROT2_RST;
            cfg_reg.shift_xy       <= '0;
            cfg_reg.shift_z        <= '0;
            cfg_reg.focal_xy       <= FOCAL_RST;
            cfg_reg.principal_xy   <= PRINC_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT0:  cfg_reg.rot_row_first  <= cfg_data[53:0];
                REG_ROT1:  cfg_reg.rot_row_second <= cfg_data[53:0];
                REG_ROT2:  cfg_reg.rot_row_third  <= cfg_data[53:0];
                REG_SHXY:  cfg_reg.shift_xy       <= cfg_data;
                REG_SHZ:   cfg_reg.shift_z        <= $signed(cfg_data[31:0]);
                REG_FOCAL: cfg_reg.focal_xy       <= cfg_data;
                REG_PRINC: cfg_reg.principal_xy   <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Response output register
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (push)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rsp_reg.range_value <= res_range;
            rsp_reg.status      <= rsp_status;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ppdb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req.command),
        .out_free    (out_free),
        .stat        (stat),
        .req_ready   (req_ready),
        .push        (push),
        .rsp_status  (rsp_status),
        .cmd         (cmd)
    );

    ppdb_dpath #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .res_range (res_range)
    );

    // Checks
    `PPDB_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)
    `PPDB_ASSERT_SAME(a_push_slot_free, clk, rst_n, push, !rsp_valid_reg || rsp_ready)
    `PPDB_ASSERT_SAME(a_no_take_on_push, clk, rst_n, push, !req_ready)

endmodule
